@@ src/ccs_pkg.sv @@
// Shared types and constants for the C comment stripper.
// Used by the front end, the command queue, the back end, the top level, the checker and the testbench.
package ccs_pkg;

	// Scanner states.
	typedef enum logic [3:0] {
		ST_CODE       = 4'd0,
		ST_STR        = 4'd1,
		ST_STR_ESC    = 4'd2,
		ST_CHR        = 4'd3,
		ST_CHR_ESC    = 4'd4,
		ST_SLASH      = 4'd5,
		ST_LINE       = 4'd6,
		ST_BLOCK      = 4'd7,
		ST_BLOCK_STAR = 4'd8
	} scan_state_t;

	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_BSLASH = 8'h5C;

	// Command queue geometry.
	localparam int QDEPTH = 4;
	localparam int QAW    = $clog2(QDEPTH);

	// One command from the front end: an optional held slash, then an
	// optional byte.
	typedef struct packed {
		logic       emit_slash;
		logic       emit_char;
		logic [7:0] ch;
	} cmd_t;

endpackage

@@ src/ccs_front.sv @@
// Front end of the C comment stripper: accepts source bytes, runs the scanner
// and turns each byte into at most one output command. Depends on ccs_pkg.
module ccs_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [7:0]    in_char,
	input  logic          q_full,
	output logic          push,
	output ccs_pkg::cmd_t push_cmd
);
	import ccs_pkg::*;

	scan_state_t state_q;
	scan_state_t state_d;
	cmd_t        cmd;
	logic        take;

	assign in_ready = !q_full;
	assign take     = in_valid && in_ready;
	assign push     = take && (cmd.emit_slash || cmd.emit_char);
	assign push_cmd = cmd;

	always_comb begin
		state_d        = state_q;
		cmd.emit_slash = 1'b0;
		cmd.emit_char  = 1'b0;
		cmd.ch         = in_char;
		case (state_q)
			ST_STR: begin
				cmd.emit_char = 1'b1;
				if (in_char == CH_DQUOTE) state_d = ST_CODE;
				else if (in_char == CH_BSLASH) state_d = ST_STR_ESC;
			end
			ST_STR_ESC: begin
				cmd.emit_char = 1'b1;
				state_d = ST_STR;
			end
			ST_CHR: begin
				cmd.emit_char = 1'b1;
				if (in_char == CH_SQUOTE) state_d = ST_CODE;
				else if (in_char == CH_BSLASH) state_d = ST_CHR_ESC;
			end
			ST_CHR_ESC: begin
				cmd.emit_char = 1'b1;
				state_d = ST_CHR;
			end
			ST_SLASH: begin
				if (in_char == CH_SLASH) begin
					state_d = ST_LINE;
				end else if (in_char == CH_STAR) begin
					state_d = ST_BLOCK;
				end else begin
					// The held slash goes out, then the byte under code rules.
					cmd.emit_slash = 1'b1;
					cmd.emit_char  = 1'b1;
					if (in_char == CH_DQUOTE) state_d = ST_STR;
					else if (in_char == CH_SQUOTE) state_d = ST_CHR;
					else state_d = ST_CODE;
				end
			end
			ST_LINE: begin
				if (in_char == CH_NL) begin
					cmd.emit_char = 1'b1;
					state_d = ST_CODE;
				end
			end
			ST_BLOCK: begin
				if (in_char == CH_STAR) state_d = ST_BLOCK_STAR;
			end
			ST_BLOCK_STAR: begin
				if (in_char == CH_SLASH) state_d = ST_CODE;
				else if (in_char != CH_STAR) state_d = ST_BLOCK;
			end
			default: begin
				if (in_char == CH_DQUOTE) begin
					cmd.emit_char = 1'b1;
					state_d = ST_STR;
				end else if (in_char == CH_SQUOTE) begin
					cmd.emit_char = 1'b1;
					state_d = ST_CHR;
				end else if (in_char == CH_SLASH) begin
					state_d = ST_SLASH;
				end else begin
					cmd.emit_char = 1'b1;
					state_d = ST_CODE;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CODE;
		end else if (take) begin
			state_q <= state_d;
		end
	end

endmodule

@@ src/ccs_queue.sv @@
// Short command queue between the front end and the back end.
// Register-based circular buffer; depends on ccs_pkg.
module ccs_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  ccs_pkg::cmd_t push_cmd,
	output logic          full,
	input  logic          pop,
	output logic          not_empty,
	output ccs_pkg::cmd_t head
);
	import ccs_pkg::*;

	cmd_t               mem_q [QDEPTH];
	logic [QAW-1:0]     wr_ptr_q;
	logic [QAW-1:0]     rd_ptr_q;
	logic [QAW:0]       count_q;
	logic               do_push;
	logic               do_pop;

	assign full      = (count_q == (QAW+1)'(QDEPTH));
	assign not_empty = (count_q != '0);
	assign head      = mem_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_push && !do_pop) count_q <= count_q + 1'b1;
			else if (do_pop && !do_push) count_q <= count_q - 1'b1;
		end
	end

endmodule

@@ src/ccs_back.sv @@
// Back end of the C comment stripper: expands queued commands into output
// bytes through a registered output stage. Depends on ccs_pkg.
module ccs_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_not_empty,
	input  ccs_pkg::cmd_t q_head,
	output logic          pop,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [7:0]    out_char,
	output logic          last_of_run
);
	import ccs_pkg::*;

	logic       valid_q;
	logic       slash_q;
	logic       has_char_q;
	logic [7:0] ch_q;
	logic       xfer;
	logic       done;

	assign out_valid   = valid_q;
	assign out_char    = slash_q ? CH_SLASH : ch_q;
	assign last_of_run = !(slash_q && has_char_q);

	assign xfer = valid_q && out_ready;
	// The current command is finished when its final byte transfers.
	assign done = xfer && last_of_run;
	assign pop  = q_not_empty && (!valid_q || done);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			slash_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
			slash_q <= q_head.emit_slash;
		end else if (done) begin
			valid_q <= 1'b0;
			slash_q <= 1'b0;
		end else if (xfer) begin
			slash_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			has_char_q <= q_head.emit_char;
			ch_q       <= q_head.ch;
		end
	end

endmodule

@@ src/c_comment_stripper_top.sv @@
// C comment stripper, top level: front scanner, command queue, back end.
// A byte's output passes through the command queue and then the output register.
// Throughput: one input byte per cycle while the queue is not full; a byte that
// releases a held slash produces two outputs and holds the output register for both.
// Reset (arst_n low, asynchronous) returns the scanner to code and empties
// the queue and the output register.
module c_comment_stripper_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_char,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_char,
	output logic       last_of_run
);
	import ccs_pkg::*;

	// Commands carry zero-output bytes nowhere: the front end only pushes
	// when at least one byte must reach the output.
	logic q_full;
	logic push;
	cmd_t push_cmd;
	logic pop;
	logic q_not_empty;
	cmd_t q_head;

	// The front end stalls only when the queue is full, so four queued commands, plus
	// the one in the output register, can back up before the input is held off.
	ccs_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_char  (in_char),
		.q_full   (q_full),
		.push     (push),
		.push_cmd (push_cmd)
	);

	ccs_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_cmd  (push_cmd),
		.full      (q_full),
		.pop       (pop),
		.not_empty (q_not_empty),
		.head      (q_head)
	);

	// The back end presents the held slash first (last_of_run low), then the
	// byte itself, and reloads from the queue in the cycle of the final
	// transfer so single-byte commands stream at one per cycle while out_ready is high and the queue is not empty.
	ccs_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_not_empty (q_not_empty),
		.q_head      (q_head),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_char    (out_char),
		.last_of_run (last_of_run)
	);

endmodule

@@ src/ccs_checker.sv @@
// Port-level checks for the C comment stripper, bound to the top level.
// Depends on ccs_pkg for the character constants.
module ccs_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_char,
	input logic       last_of_run
);
	import ccs_pkg::*;

	// A stalled output transfer keeps its byte.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_char) && $stable(last_of_run))
		else $error("output changed while stalled");

	// Only a released slash is followed by another byte of the same run.
	a_not_last_is_slash: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last_of_run |-> out_char == CH_SLASH)
		else $error("non-final byte is not a slash");

	// The second byte of a run is ready right after the slash.
	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_of_run |=> out_valid && last_of_run)
		else $error("run did not complete");

	// Nothing reaches the output without a preceding input transfer.
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 2) || $past(out_valid))
		else $error("output without input");

endmodule

bind c_comment_stripper_top ccs_checker u_ccs_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.out_char    (out_char),
	.last_of_run (last_of_run)
);

@@ tb/sv/c_comment_stripper_top_tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for c_comment_stripper_top: a directed table, then random
// C-like source text, checked byte by byte against a scanner model kept in the bench.
// Depends on ccs_pkg for the scanner state type and the character constants.
module c_comment_stripper_top_tb;
	import ccs_pkg::*;

	// Size of the random part, in source bytes.
	localparam int RAND_ITEMS = 1650;
	// Cycles without any transfer before the run is declared hung.
	localparam int IDLE_LIMIT = 2000;
	// Extra cycles after the last expected byte, to catch stray output.
	localparam int TAIL_CYCLES = 12;
	// Only the first mismatches are printed; all of them are counted.
	localparam int PRINT_MAX = 40;
	localparam int DIR_N = 28;

	// One byte of stimulus. Rows with known_out set carry the single byte the
	// stripper must pass through; all others are checked against the scanner model.
	typedef struct packed {
		logic [7:0] ch;
		logic       known_out;
		logic [7:0] want;
	} src_byte_t;

	// One byte the stripper is expected to emit.
	typedef struct packed {
		logic [7:0] ch;
		logic       last;
	} kept_byte_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [7:0] in_char = 8'h00;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [7:0] out_char;
	logic       last_of_run;

	// Directed table: extremes in code, a string with an escaped quote, a char
	// literal with an escaped apostrophe, a lone slash followed by a plain byte,
	// by a quote and by an apostrophe, a line comment that keeps its newline,
	// and a block comment with a run of stars that is broken and then closed.
	src_byte_t dir_rows [0:DIR_N-1] = '{
		'{8'h00,     1'b1, 8'h00},
		'{8'hFF,     1'b1, 8'hFF},
		'{CH_DQUOTE, 1'b0, 8'h00},
		'{CH_BSLASH, 1'b0, 8'h00},
		'{CH_DQUOTE, 1'b0, 8'h00},
		'{CH_SLASH,  1'b0, 8'h00},
		'{CH_DQUOTE, 1'b0, 8'h00},
		'{CH_SQUOTE, 1'b0, 8'h00},
		'{CH_BSLASH, 1'b0, 8'h00},
		'{CH_SQUOTE, 1'b0, 8'h00},
		'{CH_SQUOTE, 1'b0, 8'h00},
		'{CH_SLASH,  1'b0, 8'h00},
		'{8'h62,     1'b0, 8'h00},
		'{CH_SLASH,  1'b0, 8'h00},
		'{CH_DQUOTE, 1'b0, 8'h00},
		'{CH_DQUOTE, 1'b0, 8'h00},
		'{CH_SLASH,  1'b0, 8'h00},
		'{CH_SLASH,  1'b0, 8'h00},
		'{CH_NL,     1'b0, 8'h00},
		'{CH_SLASH,  1'b0, 8'h00},
		'{CH_STAR,   1'b0, 8'h00},
		'{CH_STAR,   1'b0, 8'h00},
		'{CH_STAR,   1'b0, 8'h00},
		'{8'h78,     1'b0, 8'h00},
		'{CH_STAR,   1'b0, 8'h00},
		'{CH_SLASH,  1'b0, 8'h00},
		'{CH_SLASH,  1'b0, 8'h00},
		'{CH_SQUOTE, 1'b0, 8'h00}
	};

	src_byte_t   src_q[$];
	kept_byte_t  kept_q[$];

	// Scanner model state and the bytes produced by the latest source byte.
	scan_state_t scan_now = ST_CODE;
	kept_byte_t  scan_out [0:1];
	int          scan_cnt;
	bit          state_seen [0:8];

	int          n_in = 0;
	int          n_out = 0;
	int          n_err = 0;
	int          idle_cycles = 0;
	int          rx_mode = 0;
	int          rx_left = 0;
	int          rx_tick = 0;
	kept_byte_t  got_exp;

	c_comment_stripper_top u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_char    (in_char),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_char   (out_char),
		.last_of_run(last_of_run)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic report_mismatch(input string msg);
		n_err++;
		if (n_err <= PRINT_MAX)
			$display("MISMATCH at %0t ns, output byte %0d: %s", $time, n_out, msg);
	endtask

	// Appends one byte to what the model says will leave the stripper.
	// The last flag is fixed up once the whole step is known.
	task automatic keep_byte(input logic [7:0] ch);
		scan_out[scan_cnt] = '{ch, 1'b0};
		scan_cnt++;
	endtask

	// What code does with a byte; also used for the byte after a lone slash.
	task automatic code_byte(input logic [7:0] ch);
		if (ch == CH_DQUOTE) begin
			scan_now = ST_STR;
			keep_byte(ch);
		end else if (ch == CH_SQUOTE) begin
			scan_now = ST_CHR;
			keep_byte(ch);
		end else if (ch == CH_SLASH) begin
			// The slash is held until the next byte shows what it starts.
			scan_now = ST_SLASH;
		end else begin
			scan_now = ST_CODE;
			keep_byte(ch);
		end
	endtask

	// Advances the scanner model by one source byte and fills scan_out.
	task automatic scan_byte(input logic [7:0] ch);
		scan_cnt = 0;
		case (scan_now)
			ST_STR: begin
				if (ch == CH_DQUOTE)
					scan_now = ST_CODE;
				else if (ch == CH_BSLASH)
					scan_now = ST_STR_ESC;
				keep_byte(ch);
			end
			ST_STR_ESC: begin
				scan_now = ST_STR;
				keep_byte(ch);
			end
			ST_CHR: begin
				if (ch == CH_SQUOTE)
					scan_now = ST_CODE;
				else if (ch == CH_BSLASH)
					scan_now = ST_CHR_ESC;
				keep_byte(ch);
			end
			ST_CHR_ESC: begin
				scan_now = ST_CHR;
				keep_byte(ch);
			end
			ST_SLASH: begin
				if (ch == CH_SLASH) begin
					scan_now = ST_LINE;
				end else if (ch == CH_STAR) begin
					scan_now = ST_BLOCK;
				end else begin
					// No comment after all: release the slash, then treat
					// the byte as code.
					keep_byte(CH_SLASH);
					code_byte(ch);
				end
			end
			ST_LINE: begin
				if (ch == CH_NL) begin
					scan_now = ST_CODE;
					keep_byte(ch);
				end
			end
			ST_BLOCK: begin
				if (ch == CH_STAR)
					scan_now = ST_BLOCK_STAR;
			end
			ST_BLOCK_STAR: begin
				if (ch == CH_SLASH)
					scan_now = ST_CODE;
				else if (ch != CH_STAR)
					scan_now = ST_BLOCK;
			end
			default: begin
				code_byte(ch);
			end
		endcase
		if (scan_cnt > 0)
			scan_out[scan_cnt - 1].last = 1'b1;
	endtask

	function automatic src_byte_t plain(input logic [7:0] ch);
		return '{ch, 1'b0, 8'h00};
	endfunction

	// Scoreboard. Input transfers are handled first so that the expected
	// queue is complete before an output at the same edge is compared.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				state_seen[scan_now] = 1'b1;
				scan_byte(in_char);
				if (src_q[n_in].known_out) begin
					kept_q.push_back('{src_q[n_in].want, 1'b1});
				end else begin
					for (int k = 0; k < scan_cnt; k++)
						kept_q.push_back(scan_out[k]);
				end
				n_in++;
			end
			if (out_valid && out_ready) begin
				if (kept_q.size() == 0) begin
					report_mismatch($sformatf("unexpected byte %02h", out_char));
				end else begin
					got_exp = kept_q.pop_front();
					if (out_char !== got_exp.ch)
						report_mismatch($sformatf("out_char %02h, expected %02h",
							out_char, got_exp.ch));
					if (last_of_run !== got_exp.last)
						report_mismatch($sformatf("last_of_run %b, expected %b",
							last_of_run, got_exp.last));
				end
				n_out++;
			end
		end
	end

	// Receiver. It switches between patterns: always ready, coin flips,
	// ready only when rx_tick is a multiple of three, and mostly ready with rare stalls.
	always @(posedge clk) begin
		if (rx_left == 0) begin
			rx_mode = $urandom_range(0, 3);
			rx_left = $urandom_range(20, 200);
		end else begin
			rx_left--;
		end
		rx_tick++;
		case (rx_mode)
			0: out_ready <= 1'b1;
			1: out_ready <= 1'($urandom_range(0, 1));
			2: out_ready <= (rx_tick % 3 == 0);
			default: out_ready <= ($urandom_range(0, 7) != 0);
		endcase
	end

	// Watchdog: a run that stops moving in both directions has hung.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Timeout: no transfer for %0d cycles, %0d bytes still expected",
					IDLE_LIMIT, kept_q.size());
				$display("c_comment_stripper_top_tb: FAIL");
				$finish;
			end
		end
	end

	// Stimulus: builds the byte stream, then sends it in bursts.
	initial begin
		int         pick;
		int         len;
		int         burst_left;
		int         gap;
		int         pause_at;
		int         n_seen;
		logic [7:0] b;
		logic [7:0] prev;

		for (int i = 0; i < DIR_N; i++)
			src_q.push_back(dir_rows[i]);

		// Random part: mostly well-formed C fragments with random content,
		// plus some fully random bytes that may open or break anything.
		while (src_q.size() < DIR_N + RAND_ITEMS) begin
			pick = $urandom_range(0, 99);
			if (pick < 20) begin
				// Run of code bytes; quotes and slashes are kept out.
				len = $urandom_range(1, 6);
				repeat (len) begin
					b = 8'($urandom_range(0, 255));
					if (b == CH_DQUOTE || b == CH_SQUOTE || b == CH_SLASH)
						b = 8'h3B;
					src_q.push_back(plain(b));
				end
			end else if (pick < 35) begin
				// String literal, with escapes where the content needs them and at random elsewhere.
				src_q.push_back(plain(CH_DQUOTE));
				len = $urandom_range(0, 10);
				repeat (len) begin
					b = 8'($urandom_range(0, 255));
					if (b == CH_DQUOTE || b == CH_BSLASH || $urandom_range(0, 7) == 0)
						src_q.push_back(plain(CH_BSLASH));
					src_q.push_back(plain(b));
				end
				src_q.push_back(plain(CH_DQUOTE));
			end else if (pick < 45) begin
				// Char literal, plain or escaped.
				src_q.push_back(plain(CH_SQUOTE));
				b = 8'($urandom_range(0, 255));
				if ($urandom_range(0, 1) == 1) begin
					src_q.push_back(plain(CH_BSLASH));
				end else if (b == CH_SQUOTE || b == CH_BSLASH) begin
					b = 8'h63;
				end
				src_q.push_back(plain(b));
				src_q.push_back(plain(CH_SQUOTE));
			end else if (pick < 60) begin
				// Line comment closed by a newline.
				src_q.push_back(plain(CH_SLASH));
				src_q.push_back(plain(CH_SLASH));
				len = $urandom_range(0, 10);
				repeat (len) begin
					b = 8'($urandom_range(0, 255));
					if (b == CH_NL)
						b = 8'h20;
					src_q.push_back(plain(b));
				end
				src_q.push_back(plain(CH_NL));
			end else if (pick < 75) begin
				// Block comment with star runs inside, closed by one to three
				// stars and a slash.
				src_q.push_back(plain(CH_SLASH));
				src_q.push_back(plain(CH_STAR));
				prev = 8'h00;
				len = $urandom_range(0, 12);
				repeat (len) begin
					b = ($urandom_range(0, 3) == 0) ? CH_STAR : 8'($urandom_range(0, 255));
					if (prev == CH_STAR && b == CH_SLASH)
						b = 8'h2B;
					src_q.push_back(plain(b));
					prev = b;
				end
				len = $urandom_range(1, 3);
				repeat (len)
					src_q.push_back(plain(CH_STAR));
				src_q.push_back(plain(CH_SLASH));
			end else if (pick < 90) begin
				// Lone slash followed by a byte that does not start a comment.
				src_q.push_back(plain(CH_SLASH));
				case ($urandom_range(0, 2))
					0: b = CH_DQUOTE;
					1: b = CH_SQUOTE;
					default: begin
						b = 8'($urandom_range(0, 255));
						if (b == CH_SLASH || b == CH_STAR)
							b = 8'h31;
					end
				endcase
				src_q.push_back(plain(b));
				// A quote after the slash opens a literal; close it again.
				if (b == CH_DQUOTE || b == CH_SQUOTE) begin
					src_q.push_back(plain(8'h6B));
					src_q.push_back(plain(b));
				end
			end else begin
				len = $urandom_range(1, 3);
				repeat (len)
					src_q.push_back(plain(8'($urandom_range(0, 255))));
			end
		end

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		pause_at = DIR_N + $urandom_range(RAND_ITEMS / 4, 3 * RAND_ITEMS / 4);
		burst_left = 0;
		for (int i = 0; i < src_q.size(); i++) begin
			// The sender waits for the output to drain once after the
			// directed table and once at a random point in the random part.
			if (i == DIR_N || i == pause_at) begin
				in_valid <= 1'b0;
				do @(posedge clk); while (kept_q.size() != 0);
			end else if (burst_left == 0) begin
				burst_left = $urandom_range(1, 40);
				case ($urandom_range(0, 3))
					0: gap = 0;
					1: gap = $urandom_range(1, 2);
					2: gap = $urandom_range(1, 6);
					default: gap = $urandom_range(8, 15);
				endcase
				if (gap > 0) begin
					in_valid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
			in_valid <= 1'b1;
			in_char <= src_q[i].ch;
			do @(posedge clk); while (!in_ready);
			if (burst_left > 0)
				burst_left--;
		end
		in_valid <= 1'b0;

		do @(posedge clk); while (kept_q.size() != 0);
		repeat (TAIL_CYCLES) @(posedge clk);

		n_seen = 0;
		for (int s = 0; s < 9; s++)
			n_seen += state_seen[s];
		$display("Sent %0d source bytes (%0d from the directed table), checked %0d output bytes.",
			n_in, DIR_N, n_out);
		$display("Scanner states reached: %0d of 9; mismatches: %0d.", n_seen, n_err);
		if (n_err == 0 && kept_q.size() == 0)
			$display("c_comment_stripper_top_tb: PASS");
		else
			$display("c_comment_stripper_top_tb: FAIL");
		$finish;
	end

endmodule

@@ filelist.f @@
src/ccs_pkg.sv
src/ccs_front.sv
src/ccs_queue.sv
src/ccs_back.sv
src/c_comment_stripper_top.sv
src/ccs_checker.sv
tb/sv/c_comment_stripper_top_tb.sv
